### rtl/hash_map_chained_djb2_unit_macros.svh
// Assertion macros for the chained hash map unit.
`ifndef HASH_MAP_CHAINED_DJB2_UNIT_MACROS_SVH
`define HASH_MAP_CHAINED_DJB2_UNIT_MACROS_SVH
// Check an implication on every rising clock edge outside reset.
`define HM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check an implication in the next cycle.
`define HM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/hmc_pkg.sv
// Shared types and constants of the chained hash map unit.
`default_nettype none
package hmc_pkg;
  localparam logic [31:0] HashSeed = 32'd5381;
  localparam int unsigned HashShift = 5;
  localparam logic [31:0] MissValue = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture item, start hash
    logic hash_step;  // fold one key byte
    logic head_rd;    // fetch bucket head into cursor
    logic node_rd;    // fetch node at cursor
    logic advance;    // prev <= cur, cur <= next
    logic alloc_step; // scan one free bit
    logic wr_update;  // overwrite value at cursor
    logic wr_insert;  // write new node and head
    logic wr_unlink;  // unlink cursor node
    logic res_hit;
    logic res_miss;
    logic res_full;
    logic res_zero;
    logic out_load;   // copy result into output register
  } hmc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_done;
    logic cur_null;
    logic key_match;
    logic walk_limit;
    logic alloc_found;
    logic alloc_done;
  } hmc_sts_t;
endpackage
`default_nettype wire

### rtl/hmc_ctrl.sv
// Controller state machine of the chained hash map unit.
`default_nettype none
module hmc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire logic [1:0]       opcode_i,
  input  wire hmc_pkg::hmc_sts_t sts_i,
  output hmc_pkg::hmc_cmd_t     cmd_o
);
  import hmc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HASH  = 10'b0000000010,
    S_HEAD  = 10'b0000000100,
    S_READ  = 10'b0000001000,
    S_CMP   = 10'b0000010000,
    S_ALLOC = 10'b0000100000,
    S_WRITE = 10'b0001000000,
    S_OUT   = 10'b0010000000,
    S_ADV   = 10'b0100000000,
    S_HIT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  op_e op_q, op_d;
  logic out_valid_q, out_valid_d;

  assign in_stall  = (state_q != S_IDLE);
  assign out_valid = out_valid_q;

  // Sequence hash, chain walk, allocate and write.
  always_comb begin
    state_d = state_q;
    op_d = op_q;
    out_valid_d = out_valid_q && out_stall;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd_o.load = 1'b1;
          op_d = op_e'(opcode_i);
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (op_q == OP_NONE) begin
          cmd_o.res_zero = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.hash_done) begin
          state_d = S_HEAD;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_HEAD: begin
        cmd_o.head_rd = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        if (sts_i.cur_null || sts_i.walk_limit) begin
          if (op_q == OP_INSERT) begin
            state_d = S_ALLOC;
          end else begin
            cmd_o.res_miss = 1'b1;
            state_d = S_OUT;
          end
        end else begin
          cmd_o.node_rd = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.key_match) begin
          state_d = S_HIT;
        end else begin
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        cmd_o.advance = 1'b1;
        state_d = S_READ;
      end
      S_HIT: begin
        cmd_o.res_hit = 1'b1;
        cmd_o.wr_update = (op_q == OP_INSERT);
        cmd_o.wr_unlink = (op_q == OP_REMOVE);
        state_d = S_OUT;
      end
      S_ALLOC: begin
        if (sts_i.alloc_found) begin
          state_d = S_WRITE;
        end else if (sts_i.alloc_done) begin
          cmd_o.res_full = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.alloc_step = 1'b1;
        end
      end
      S_WRITE: begin
        cmd_o.wr_insert = 1'b1;
        cmd_o.res_zero = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free or being taken.
        if (!out_valid_q || !out_stall) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

### rtl/hmc_datapath.sv
// Datapath of the chained hash map unit: hash, node memories and result.
`default_nettype none
module hmc_datapath #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned NODE_POOL = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic signed [31:0] key_i,
  input  wire logic signed [31:0] value_i,
  input  wire hmc_pkg::hmc_cmd_t cmd_i,
  output hmc_pkg::hmc_sts_t      sts_o,
  output logic                   found_o,
  output logic signed [31:0]     read_value_o,
  output logic                   pool_full_o
);
  import hmc_pkg::*;

  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned NW = $clog2(NODE_POOL + 1);
  localparam int unsigned IW = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam logic [NW-1:0] NullLink = NW'(NODE_POOL);
  // Rounded-up reciprocal of the bucket count, exact for every 32-bit hash.
  localparam logic [63:0] RecipMul =
    ((64'd1 << (32 + BW)) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);

  logic [31:0] key_q, val_q, hash_q, rd_q;
  logic [2:0] byte_q;
  logic [NW-1:0] cur_q, prev_q, nxt_q, pick_q, steps_q;
  logic [31:0] nkey_q;
  logic pick_ok_q;
  logic found_q, full_q;
  logic [31:0] quot_q;

  logic [NW-1:0] head_q [NUM_BUCKETS];
  logic [NODE_POOL-1:0] free_q;
  logic [31:0] mem_key [NODE_POOL];
  logic [31:0] mem_val [NODE_POOL];
  logic [NW-1:0] mem_next [NODE_POOL];

  logic [7:0] cur_byte;
  logic [BW-1:0] bucket;
  logic [IW-1:0] cur_idx, prev_idx, pick_idx;
  logic [64:0] hash_prod;
  logic [31:0] hash_rem;

  assign cur_byte = key_q[8*byte_q[1:0] +: 8];
  assign cur_idx = cur_q[IW-1:0];
  assign prev_idx = prev_q[IW-1:0];
  assign pick_idx = pick_q[IW-1:0];

  // Reduce the hash to a bucket: quotient registered, remainder from it.
  // The hash is final in the cycle before the head fetch, so the quotient is ready.
  assign hash_prod = {33'd0, hash_q} * {32'd0, RecipMul[32:0]};
  assign hash_rem = hash_q - 32'(quot_q * 32'(NUM_BUCKETS));
  assign bucket = hash_rem[BW-1:0];

  always_ff @(posedge clk_i) begin
    quot_q <= 32'(hash_prod >> (32 + BW));
  end

  assign sts_o.hash_done = byte_q[2] || (cur_byte == 8'd0);
  assign sts_o.cur_null = (cur_q >= NullLink);
  assign sts_o.key_match = (nkey_q == key_q);
  assign sts_o.walk_limit = (steps_q >= NullLink);
  assign sts_o.alloc_found = pick_ok_q;
  assign sts_o.alloc_done = (pick_q >= NullLink);

  // Hash, walk cursor and free scan registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
      val_q <= value_i;
      hash_q <= HashSeed;
      byte_q <= 3'd0;
      pick_q <= '0;
      pick_ok_q <= 1'b0;
      steps_q <= '0;
    end
    if (cmd_i.hash_step) begin
      hash_q <= (hash_q << HashShift) + hash_q + {24'd0, cur_byte};
      byte_q <= byte_q + 3'd1;
    end
    if (cmd_i.head_rd) begin
      cur_q <= head_q[bucket];
      prev_q <= NullLink;
    end
    if (cmd_i.node_rd) begin
      nkey_q <= mem_key[cur_idx];
      nxt_q <= mem_next[cur_idx];
    end
    if (cmd_i.advance) begin
      prev_q <= cur_q;
      cur_q <= nxt_q;
      steps_q <= steps_q + NW'(1);
    end
    if (cmd_i.alloc_step) begin
      if (free_q[pick_idx]) pick_ok_q <= 1'b1;
      else pick_q <= pick_q + NW'(1);
    end
  end

  // Write node memories; a freed node keeps its stale link until reused.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_update) mem_val[cur_idx] <= val_q;
    if (cmd_i.wr_insert) begin
      mem_key[pick_idx] <= key_q;
      mem_val[pick_idx] <= val_q;
      mem_next[pick_idx] <= head_q[bucket];
    end
    if (cmd_i.wr_unlink) begin
      if (prev_q < NullLink) mem_next[prev_idx] <= nxt_q;
    end
    if (cmd_i.res_hit) rd_q <= mem_val[cur_idx];
  end

  // Bucket heads and free flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUCKETS; i++) head_q[i] <= NullLink;
      free_q <= '1;
    end else begin
      if (cmd_i.wr_insert) begin
        head_q[bucket] <= pick_q;
        free_q[pick_idx] <= 1'b0;
      end
      if (cmd_i.wr_unlink) begin
        free_q[cur_idx] <= 1'b1;
        if (prev_q >= NullLink) head_q[bucket] <= nxt_q;
      end
    end
  end

  // Result flags.
  logic lookup_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) lookup_q <= 1'b0;
    if (cmd_i.res_hit) begin
      found_q <= 1'b1;
      full_q <= 1'b0;
      lookup_q <= !cmd_i.wr_update && !cmd_i.wr_unlink;
    end
    if (cmd_i.res_miss || cmd_i.res_zero) begin
      found_q <= 1'b0;
      full_q <= 1'b0;
      lookup_q <= 1'b0;
    end
    if (cmd_i.res_full) begin
      found_q <= 1'b0;
      full_q <= 1'b1;
      lookup_q <= 1'b0;
    end
  end

  // Miss value depends on opcode: the controller raises res_miss for lookup and remove.
  logic miss_lookup_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) miss_lookup_q <= 1'b0;
    if (cmd_i.res_miss) miss_lookup_q <= 1'b1;
  end

  logic [31:0] res_rd;
  assign res_rd = lookup_q ? rd_q : (miss_lookup_q && !found_q ? MissValue : 32'd0);

  // Output register: hold the item while it waits on the receiver.
  logic out_found_q, out_full_q;
  logic [31:0] out_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_found_q <= 1'b0;
      out_full_q <= 1'b0;
      out_rd_q <= '0;
    end else if (cmd_i.out_load) begin
      out_found_q <= found_q;
      out_full_q <= full_q;
      out_rd_q <= res_rd;
    end
  end

  assign found_o = out_found_q;
  assign pool_full_o = out_full_q;
  assign read_value_o = out_rd_q;
endmodule
`default_nettype wire

### rtl/hash_map_chained_djb2_unit.sv
// Top level of the chained hash map unit.
//  channel | valid     | stall      | fields
//  in      | in_valid  | in_stall   | opcode_i key_i value_i
//  out     | out_valid | out_stall  | found_o read_value_o pool_full_o
// One item at a time: the key is hashed a byte at a time, then the chain is walked
// node by node; a hit updates, unlinks or reads the node, an insert of a new key
// scans the free flags for a slot, and an insert that finds the pool full scans them all.
// Reset clears bucket heads and free flags at once; no clearing pass.
// The result waits in an output register; the next item runs meanwhile and
// holds in its last cycle while that result is stalled.
`default_nettype none
module hash_map_chained_djb2_unit #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned NODE_POOL = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        opcode_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic signed [31:0] value_i,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   found_o,
  output logic signed [31:0]     read_value_o,
  output logic                   pool_full_o
);
  import hmc_pkg::*;

  hmc_cmd_t cmd;
  hmc_sts_t sts;
  logic [1:0] opc;

  // Pass the opcode to the controller.
  assign opc = opcode_i;

  hmc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .opcode_i(opc), .sts_i(sts), .cmd_o(cmd)
  );

  hmc_cmd_t cmd_dp;
  logic is_lookup_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) is_lookup_q <= 1'b0;
    else if (cmd.load) is_lookup_q <= (opcode_i == OP_LOOKUP);
  end
  // Only a lookup miss yields the miss value; a remove miss reads zero.
  always_comb begin
    cmd_dp = cmd;
    if (cmd.res_miss && !is_lookup_q) begin
      cmd_dp.res_miss = 1'b0;
      cmd_dp.res_zero = 1'b1;
    end
  end

  hmc_datapath #(.NUM_BUCKETS(NUM_BUCKETS), .NODE_POOL(NODE_POOL)) u_dp (
    .clk_i, .rst_ni, .key_i, .value_i, .cmd_i(cmd_dp), .sts_o(sts),
    .found_o, .read_value_o, .pool_full_o
  );
endmodule
`default_nettype wire

### rtl/hmc_checker.sv
// Port checker of the chained hash map unit and its bind.
`default_nettype none
`include "hash_map_chained_djb2_unit_macros.svh"
module hmc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        found_o,
  input wire logic [31:0] read_value_o,
  input wire logic        pool_full_o
);
  `HM_ASSERT_IMP(a_full_not_found, clk_i, rst_ni, out_valid, !(found_o && pool_full_o), "full and found")
  `HM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid && !in_stall, in_stall, "accept not busy")
  `HM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(read_value_o), "result dropped")
  `HM_ASSERT_IMP(a_full_zero, clk_i, rst_ni, out_valid && pool_full_o, read_value_o == 32'd0, "full value")
endmodule
bind hash_map_chained_djb2_unit hmc_checker u_hmc_checker (.*);
`default_nettype wire

### test/tb_hash_map_chained_djb2_unit.sv
// Self-checking testbench of the chained djb2 hash map unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_hash_map_chained_djb2_unit;
  import hmc_pkg::*;

  localparam int unsigned NBUCK = 16;
  localparam int unsigned NPOOL = 64;
  localparam int unsigned NULL_IDX = NPOOL;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 1010;

  typedef struct packed {
    logic        found;
    logic [31:0] rd;
    logic        full;
  } map_result_t;

  typedef struct {
    op_e         op;
    logic [31:0] key;
    logic [31:0] val;
    bit          typed;
    map_result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode_i = '0;
  logic signed [31:0] key_i = '0;
  logic signed [31:0] value_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found_o;
  logic signed [31:0] read_value_o;
  logic pool_full_o;

  hash_map_chained_djb2_unit dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .opcode_i, .key_i, .value_i,
    .out_valid, .out_stall, .found_o, .read_value_o, .pool_full_o
  );

  // Mirror of the map contents.
  int unsigned head_q[NBUCK];
  logic [31:0] nkey[NPOOL];
  logic [31:0] nval[NPOOL];
  int unsigned nnext[NPOOL];
  bit          nfree[NPOOL];

  map_result_t pending_q[$];
  logic [31:0] live_keys[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned full_seen = 0;
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 56;
  bit          hold_recv = 1'b0;
  bit          sim_done = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned djb2_bucket(logic [31:0] k);
    logic [31:0] h;
    logic [7:0] b;
    h = 32'd5381;
    for (int i = 0; i < 4; i++) begin
      b = k[8*i +: 8];
      if (b == 8'd0) break;
      h = (h << 5) + h + {24'd0, b};
    end
    return h % NBUCK;
  endfunction

  // Apply one operation to the mirror and return the expected result.
  function automatic map_result_t map_apply(op_e op, logic [31:0] k, logic [31:0] v);
    map_result_t r;
    int unsigned bk, cur, prv, hit, pick, steps;
    r = '0;
    bk = djb2_bucket(k);
    cur = head_q[bk];
    prv = NULL_IDX;
    hit = NULL_IDX;
    steps = 0;
    if (op == OP_NONE) return r;
    while (cur < NULL_IDX && steps < NPOOL) begin
      if (nkey[cur] == k) begin
        hit = cur;
        break;
      end
      prv = cur;
      cur = nnext[cur];
      steps++;
    end
    r.found = (hit < NULL_IDX);
    case (op)
      OP_INSERT: begin
        if (hit < NULL_IDX) begin
          nval[hit] = v;
        end else begin
          pick = NULL_IDX;
          for (int i = 0; i < NPOOL; i++) if (nfree[i]) begin
            pick = i;
            break;
          end
          if (pick < NULL_IDX) begin
            nfree[pick] = 1'b0;
            nkey[pick] = k;
            nval[pick] = v;
            nnext[pick] = head_q[bk];
            head_q[bk] = pick;
          end else begin
            r.full = 1'b1;
          end
        end
      end
      OP_LOOKUP: begin
        r.rd = (hit < NULL_IDX) ? nval[hit] : MissValue;
      end
      OP_REMOVE: begin
        if (hit < NULL_IDX) begin
          if (prv < NULL_IDX) nnext[prv] = nnext[hit];
          else head_q[bk] = nnext[hit];
          nnext[hit] = NULL_IDX;
          nfree[hit] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track which keys are live so random traffic can aim at them.
  task automatic note_key(op_e op, logic [31:0] k, map_result_t r);
    int idx[$];
    idx = live_keys.find_first_index(x) with (x == k);
    if (op == OP_INSERT && !r.full && idx.size() == 0) live_keys = {live_keys, k};
    if (op == OP_REMOVE && idx.size() != 0) live_keys.delete(idx[0]);
  endtask

  // Offer one item and hold it until accepted.
  task automatic send_item(op_e op, logic [31:0] k, logic [31:0] v, bit typed,
                           map_result_t typed_res);
    map_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    opcode_i <= op;
    key_i <= k;
    value_i <= v;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    r = map_apply(op, k, v);
    if (typed && r != typed_res) begin
      $display("%0t: typed row disagrees with mirror, typed %h mirror %h",
               $time, typed_res, r);
      errors++;
    end
    pending_q = {pending_q, (typed ? typed_res : r)};
    note_key(op, k, r);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55 && live_keys.size() != 0) return live_keys[$urandom_range(live_keys.size() - 1)];
    if (sel < 75) return {16'd0, 8'($urandom_range(255)), 8'($urandom_range(255))};
    if (sel < 85) return {24'd0, 8'($urandom_range(255))} << (8 * $urandom_range(3));
    return $urandom;
  endfunction

  // Receiver stall pattern, including one long hold-off.
  always @(negedge clk_i) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check results at the rising edge.
  always @(posedge clk_i) begin
    map_result_t exp_r;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected, actual %b %h %b", $time,
                 found_o, read_value_o, pool_full_o);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (exp_r.found) hits_seen++;
        if (exp_r.full) full_seen++;
        if (found_o !== exp_r.found) begin
          $display("%0t: found expected %b actual %b", $time, exp_r.found, found_o);
          errors++;
        end
        if (read_value_o !== exp_r.rd) begin
          $display("%0t: read_value expected %h actual %h", $time, exp_r.rd, read_value_o);
          errors++;
        end
        if (pool_full_o !== exp_r.full) begin
          $display("%0t: pool_full expected %b actual %b", $time, exp_r.full, pool_full_o);
          errors++;
        end
      end
    end
  end

  // Run-length guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT && !sim_done) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  stim_row_t dir_rows[$];

  task automatic add_row(op_e op, logic [31:0] k, logic [31:0] v, bit typed,
                         logic f, logic [31:0] rd, logic fl);
    stim_row_t s;
    s.op = op; s.key = k; s.val = v; s.typed = typed;
    s.res.found = f; s.res.rd = rd; s.res.full = fl;
    dir_rows = {dir_rows, s};
  endtask

  initial begin
    int unsigned phase_len;
    op_e op;
    for (int i = 0; i < NBUCK; i++) head_q[i] = NULL_IDX;
    for (int i = 0; i < NPOOL; i++) begin
      nkey[i] = '0; nval[i] = '0; nnext[i] = NULL_IDX; nfree[i] = 1'b1;
    end
    // Directed table: empty map, extremes, unused opcode, misses.
    add_row(OP_LOOKUP, 32'h0000_0000, 32'h0, 1, 0, MissValue, 0);
    add_row(OP_REMOVE, 32'h1234_5678, 32'h0, 1, 0, 32'h0, 0);
    add_row(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 32'h0, 0);
    add_row(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 32'h0, 0);
    add_row(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 32'h0, 0);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 32'h0, 0);
    add_row(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1, 0, 32'h0, 0);
    add_row(OP_LOOKUP, 32'h8000_0000, 32'h0, 1, 1, 32'h7FFF_FFFF, 0);
    add_row(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1, 1, 32'h8000_0000, 0);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 32'h5555_AAAA, 1, 1, 32'h0, 0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1, 1, 32'h5555_AAAA, 0);
    add_row(OP_NONE, 32'h0000_0000, 32'h0, 1, 0, 32'h0, 0);
    add_row(OP_REMOVE, 32'h0000_0000, 32'h0, 1, 1, 32'h0, 0);
    add_row(OP_LOOKUP, 32'h0000_0000, 32'h0, 1, 0, MissValue, 0);
    // Keys sharing a bucket: remove from middle and head of a chain.
    add_row(OP_INSERT, 32'h0000_0001, 32'h11, 0, 0, 0, 0);
    add_row(OP_INSERT, 32'h0000_0011, 32'h22, 0, 0, 0, 0);
    add_row(OP_INSERT, 32'h0000_0021, 32'h33, 0, 0, 0, 0);
    add_row(OP_REMOVE, 32'h0000_0011, 32'h0, 0, 0, 0, 0);
    add_row(OP_LOOKUP, 32'h0000_0001, 32'h0, 0, 0, 0, 0);
    add_row(OP_REMOVE, 32'h0000_0021, 32'h0, 0, 0, 0, 0);
    add_row(OP_LOOKUP, 32'h0000_0021, 32'h0, 0, 0, 0, 0);
    add_row(OP_REMOVE, 32'h8000_0000, 32'h0, 0, 0, 0, 0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val, dir_rows[i].typed,
                dir_rows[i].res);

    // Fill the pool to exhaustion, starting with a long receiver hold-off.
    fork
      begin
        hold_recv = 1'b1;
        for (int c = 0; c < 3000; c++) @(negedge clk_i);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < NPOOL + 4; i++)
        send_item(OP_INSERT, 32'h0100_0000 + i, $urandom, 0, '0);
    join

    // Random traffic in three idling phases.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 28 : (p == 1) ? 56 : 0;
      recv_idle_pct = (p == 0) ? 56 : (p == 1) ? 28 : 0;
      phase_len = RANDOM_ITEMS / 3;
      for (int i = 0; i < phase_len; i++) begin
        case ($urandom_range(99)) inside
          [0:39]:  op = OP_INSERT;
          [40:69]: op = OP_LOOKUP;
          [70:96]: op = OP_REMOVE;
          default: op = OP_NONE;
        endcase
        send_item(op, pick_key(), $urandom, 0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sim_done = 1'b1;
    $display("Covered %0d results: %0d hits, %0d pool-full rejections,",
             results_seen, hits_seen, full_seen);
    $display("all opcodes incl. unused, chain unlinks and a long receiver hold-off.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/hmc_pkg.sv
rtl/hmc_ctrl.sv
rtl/hmc_datapath.sv
rtl/hash_map_chained_djb2_unit.sv
rtl/hmc_checker.sv
test/tb_hash_map_chained_djb2_unit.sv
